/* hdl/snpu_pkg.sv */
// Shared types and constants for the spiking neuron potential update core.
`default_nettype none

package snpu_pkg;

  // Potential word and configuration field widths.
  localparam int POT_W     = 48;
  localparam int THR_W     = 16;
  localparam int REST_W    = 16;
  localparam int DECAY_W   = 7;
  localparam int BASE_W    = 8;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int TYPE_W    = 8;
  localparam int POWER_W   = 5;

  // Operand magnitude width: the ratio numerator reaches 255 + 127.
  localparam int OPW = 9;

  // Divider: the dividend is padded to DVD_W and retires DIV_STEP_BITS a cycle.
  localparam int DVD_W         = 64;
  localparam int DIV_STEP_BITS = 8;
  localparam int DIV_CYCLES    = DVD_W / DIV_STEP_BITS;
  localparam int DIV_CNT_W     = $clog2(DIV_CYCLES);

  // Step counter holds a power magnitude of up to sixteen.
  localparam int STEP_W = POWER_W;

  // Percent scale of the decay.
  localparam logic [DECAY_W-1:0] PCT_SCALE = 7'd100;

  // Saturation limits of the potential.
  localparam logic [POT_W-1:0] POT_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [POT_W-1:0] POT_MIN = 48'h8000_0000_0000;

  // Register reset values.
  localparam logic [THR_W-1:0]   THR_RESET   = 16'd100;
  localparam logic [REST_W-1:0]  REST_RESET  = 16'd10;
  localparam logic [DECAY_W-1:0] DECAY_RESET = 7'd10;
  localparam logic [BASE_W-1:0]  BASE_RESET  = 8'd5;

  // Item commands.
  localparam logic CMD_SYNAPSE = 1'b0;
  localparam logic CMD_TICK    = 1'b1;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_REST      = 2'd1,
    CFG_DECAY     = 2'd2,
    CFG_BASE      = 2'd3
  } cfg_idx_t;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_REST,
    ST_ZSAT,
    ST_MUL,
    ST_DIV,
    ST_CLAMP,
    ST_FIRE,
    ST_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic rest;
    logic zsat;
    logic mul;
    logic div;
    logic clamp;
    logic fire;
    logic out_load;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_tick;
    logic skip;
    logic div_zero;
    logic rest_hit;
    logic last_step;
    logic div_last;
  } dp_status_t;

endpackage

`default_nettype wire

/* hdl/spiking_neuron_potential_update_core.sv */
// Top level: configuration registers, controller and datapath of the neuron core.
// A tick at or below rest goes to rest and then the fire check, a tick above rest decays
// and then the fire check; a synapse goes straight to finish when skipped, saturates on divide by
// zero, and otherwise runs n power steps for a power of n (at most eight by default).
// Each power step is one 48x9 multiply, a division by an 8-bit-per-cycle divider
// and a clamp; one transaction is processed at a time, the next is taken once idle.
// Synchronous active-high reset restores register defaults, rest potential, inactive.
`default_nettype none

module spiking_neuron_potential_update_core #(
  parameter int FRAC_BITS = 16,
  parameter int MAX_POWER = 8
) (
  input  wire                                      clk,
  input  wire                                      rst,
  input  wire                                      cfg_we,
  input  wire        [snpu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire        [snpu_pkg::CFG_W-1:0]         cfg_data,
  input  wire                                      in_valid,
  output logic                                     in_ready,
  input  wire                                      cmd,
  input  wire signed [snpu_pkg::TYPE_W-1:0]        psp_type,
  input  wire signed [snpu_pkg::POWER_W-1:0]       psp_power,
  output logic                                     out_valid,
  input  wire                                      out_ready,
  output logic                                     spike,
  output logic signed [snpu_pkg::POT_W-1:0]        potential_out,
  output logic                                     active_out,
  output logic                                     saturated
);

  logic [snpu_pkg::THR_W-1:0]   fire_threshold;
  logic [snpu_pkg::REST_W-1:0]  rest_level;
  logic [snpu_pkg::DECAY_W-1:0] decay_percent;
  logic [snpu_pkg::BASE_W-1:0]  psp_base;
  snpu_pkg::ctrl_cmd_t          ctl;
  snpu_pkg::dp_status_t         st;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      fire_threshold <= snpu_pkg::THR_RESET;
      rest_level     <= snpu_pkg::REST_RESET;
      decay_percent  <= snpu_pkg::DECAY_RESET;
      psp_base       <= snpu_pkg::BASE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        snpu_pkg::CFG_THRESHOLD: fire_threshold <= cfg_data[snpu_pkg::THR_W-1:0];
        snpu_pkg::CFG_REST:      rest_level     <= cfg_data[snpu_pkg::REST_W-1:0];
        snpu_pkg::CFG_DECAY:     decay_percent  <= cfg_data[snpu_pkg::DECAY_W-1:0];
        snpu_pkg::CFG_BASE:      psp_base       <= cfg_data[snpu_pkg::BASE_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer.
  snpu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .ctl       (ctl)
  );

  // Arithmetic and neuron state.
  snpu_dp #(
    .FRAC_BITS (FRAC_BITS),
    .MAX_POWER (MAX_POWER)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl),
    .st             (st),
    .fire_threshold (fire_threshold),
    .rest_level     (rest_level),
    .decay_percent  (decay_percent),
    .psp_base       (psp_base),
    .cmd            (cmd),
    .psp_type       (psp_type),
    .psp_power      (psp_power),
    .spike          (spike),
    .potential_out  (potential_out),
    .active_out     (active_out),
    .saturated      (saturated)
  );

endmodule

`default_nettype wire

/* hdl/snpu_ctrl.sv */
// Controller state machine that sequences the potential update datapath.
`default_nettype none

module snpu_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire                  out_ready,
  input  snpu_pkg::dp_status_t st,
  output snpu_pkg::ctrl_cmd_t  ctl
);

  snpu_pkg::state_t state;
  snpu_pkg::state_t state_next;
  logic             out_free;

  // The output register can take a new result when empty or being drained.
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == snpu_pkg::ST_IDLE);

  // State and output-valid registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= snpu_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      snpu_pkg::ST_IDLE: begin
        if (in_valid) state_next = snpu_pkg::ST_DECODE;
      end
      snpu_pkg::ST_DECODE: begin
        if (st.is_tick) begin
          state_next = st.rest_hit ? snpu_pkg::ST_REST : snpu_pkg::ST_MUL;
        end else if (st.skip) begin
          state_next = snpu_pkg::ST_FINISH;
        end else if (st.div_zero) begin
          state_next = snpu_pkg::ST_ZSAT;
        end else begin
          state_next = snpu_pkg::ST_MUL;
        end
      end
      snpu_pkg::ST_REST:  state_next = snpu_pkg::ST_FIRE;
      snpu_pkg::ST_ZSAT:  state_next = snpu_pkg::ST_FINISH;
      snpu_pkg::ST_MUL:   state_next = snpu_pkg::ST_DIV;
      snpu_pkg::ST_DIV: begin
        if (st.div_last) state_next = snpu_pkg::ST_CLAMP;
      end
      snpu_pkg::ST_CLAMP: begin
        if (st.last_step) begin
          state_next = st.is_tick ? snpu_pkg::ST_FIRE : snpu_pkg::ST_FINISH;
        end else begin
          state_next = snpu_pkg::ST_MUL;
        end
      end
      snpu_pkg::ST_FIRE:  state_next = snpu_pkg::ST_FINISH;
      snpu_pkg::ST_FINISH: begin
        if (out_free) state_next = snpu_pkg::ST_IDLE;
      end
      default: state_next = snpu_pkg::ST_IDLE;
    endcase
  end

  // Command outputs.
  always_comb begin
    ctl          = '0;
    ctl.load     = (state == snpu_pkg::ST_IDLE) && in_valid;
    ctl.rest     = (state == snpu_pkg::ST_REST);
    ctl.zsat     = (state == snpu_pkg::ST_ZSAT);
    ctl.mul      = (state == snpu_pkg::ST_MUL);
    ctl.div      = (state == snpu_pkg::ST_DIV);
    ctl.clamp    = (state == snpu_pkg::ST_CLAMP);
    ctl.fire     = (state == snpu_pkg::ST_FIRE);
    ctl.out_load = (state == snpu_pkg::ST_FINISH) && out_free;
  end

  // A finished item shows up on the output on the next cycle once the output register is free.
  a_finish_shows: assert property (@(posedge clk) disable iff (rst)
    (state == snpu_pkg::ST_FINISH && out_free) |=> out_valid)
    else $error("finished result did not reach the output register");

  // A new result appears only from the finish state.
  a_valid_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == snpu_pkg::ST_FINISH)
    else $error("output valid rose outside the finish state");

  // The divider always runs after a multiply.
  a_mul_then_div: assert property (@(posedge clk) disable iff (rst)
    (state == snpu_pkg::ST_MUL) |=> (state == snpu_pkg::ST_DIV))
    else $error("multiply was not followed by division");

endmodule

`default_nettype wire

/* hdl/snpu_dp.sv */
// Datapath: neuron state, operand setup, multiplier, radix-256 divider and clamp.
`default_nettype none

module snpu_dp #(
  parameter int FRAC_BITS = 16,
  parameter int MAX_POWER = 8
) (
  input  wire                                      clk,
  input  wire                                      rst,
  input  snpu_pkg::ctrl_cmd_t                      ctl,
  output snpu_pkg::dp_status_t                     st,
  input  wire        [snpu_pkg::THR_W-1:0]         fire_threshold,
  input  wire        [snpu_pkg::REST_W-1:0]        rest_level,
  input  wire        [snpu_pkg::DECAY_W-1:0]       decay_percent,
  input  wire        [snpu_pkg::BASE_W-1:0]        psp_base,
  input  wire                                      cmd,
  input  wire signed [snpu_pkg::TYPE_W-1:0]        psp_type,
  input  wire signed [snpu_pkg::POWER_W-1:0]       psp_power,
  output logic                                     spike,
  output logic signed [snpu_pkg::POT_W-1:0]        potential_out,
  output logic                                     active_out,
  output logic                                     saturated
);

  localparam int POT_W = snpu_pkg::POT_W;
  localparam int OPW   = snpu_pkg::OPW;
  localparam int DVD_W = snpu_pkg::DVD_W;
  localparam int PROD_W = POT_W + OPW;

  // Neuron state and per-item working registers.
  logic signed [POT_W-1:0]              potential;
  logic                                 active;
  logic                                 is_tick;
  logic                                 sat;
  logic                                 spike_r;
  logic [OPW-1:0]                       mul_mag;
  logic [OPW-1:0]                       div_mag;
  logic                                 ops_neg;
  logic                                 res_neg;
  logic [snpu_pkg::STEP_W-1:0]          steps;
  logic [DVD_W-1:0]                     dvd;
  logic [OPW-1:0]                       rem;
  logic [snpu_pkg::DIV_CNT_W-1:0]       div_cnt;

  // Operand decode signals.
  logic signed [OPW:0]                  numer;
  logic                                 numer_neg;
  logic [OPW-1:0]                       numer_mag;
  logic [OPW-1:0]                       base_ext;
  logic [snpu_pkg::POWER_W-1:0]         pw_mag_raw;
  logic [snpu_pkg::STEP_W-1:0]          pw_mag;
  logic [snpu_pkg::DECAY_W-1:0]         decay_sat;
  logic [OPW-1:0]                       factor;

  // Thresholds and arithmetic results.
  logic [POT_W-1:0]                     rest_val;
  logic [POT_W-1:0]                     thr_val;
  logic [POT_W-1:0]                     pot_mag;
  logic [PROD_W-1:0]                    prod;
  logic [DVD_W-1:0]                     dvd_next;
  logic [OPW-1:0]                       rem_next;
  logic                                 ovf;
  logic [POT_W-1:0]                     clamp_val;

  // Ratio numerator and power magnitude from the incoming item.
  assign numer      = $signed({2'b00, psp_base}) +
                      $signed({{(OPW + 1 - snpu_pkg::TYPE_W){psp_type[snpu_pkg::TYPE_W-1]}},
                               psp_type});
  assign numer_neg  = numer[OPW];
  assign numer_mag  = numer_neg ? OPW'(-numer) : numer[OPW-1:0];
  assign base_ext   = OPW'(psp_base);
  assign pw_mag_raw = psp_power[snpu_pkg::POWER_W-1] ? snpu_pkg::POWER_W'(-psp_power)
                                                     : psp_power;
  assign pw_mag     = (int'(pw_mag_raw) > MAX_POWER) ? snpu_pkg::STEP_W'(MAX_POWER)
                                                     : pw_mag_raw;

  // Decay factor, with the percentage limited to the full scale.
  assign decay_sat = (decay_percent > snpu_pkg::PCT_SCALE) ? snpu_pkg::PCT_SCALE
                                                           : decay_percent;
  assign factor    = OPW'(snpu_pkg::PCT_SCALE - decay_sat);

  // Integer levels scaled to the fixed-point format.
  assign rest_val = POT_W'(rest_level) << FRAC_BITS;
  assign thr_val  = POT_W'(fire_threshold) << FRAC_BITS;

  // Magnitude of the potential and the product for one step.
  assign pot_mag = potential[POT_W-1] ? POT_W'(-potential) : POT_W'(potential);
  assign prod    = PROD_W'(pot_mag) * PROD_W'(mul_mag);

  // Divider: DIV_STEP_BITS restoring steps on a narrow remainder per cycle.
  always_comb begin
    logic [OPW:0]     r;
    logic [DVD_W-1:0] d;
    r = {1'b0, rem};
    d = dvd;
    for (int i = 0; i < snpu_pkg::DIV_STEP_BITS; i++) begin
      r = {r[OPW-1:0], d[DVD_W-1]};
      d = {d[DVD_W-2:0], 1'b0};
      if (r >= {1'b0, div_mag}) begin
        r    = r - {1'b0, div_mag};
        d[0] = 1'b1;
      end
    end
    dvd_next = d;
    rem_next = r[OPW-1:0];
  end

  // Apply the sign to the quotient and clip it to the potential range.
  always_comb begin
    if (res_neg) begin
      ovf       = dvd > DVD_W'(snpu_pkg::POT_MIN);
      clamp_val = ovf ? snpu_pkg::POT_MIN : POT_W'(-dvd[POT_W-1:0]);
    end else begin
      ovf       = dvd > DVD_W'(snpu_pkg::POT_MAX);
      clamp_val = ovf ? snpu_pkg::POT_MAX : dvd[POT_W-1:0];
    end
  end

  // Status toward the controller.
  assign st.is_tick   = is_tick;
  assign st.skip      = !active || (steps == '0);
  assign st.div_zero  = (steps != '0) && (div_mag == '0);
  assign st.rest_hit  = $signed(potential) <= $signed(rest_val);
  assign st.last_step = (steps == snpu_pkg::STEP_W'(1));
  assign st.div_last  = (div_cnt == snpu_pkg::DIV_CNT_W'(snpu_pkg::DIV_CYCLES - 1));

  // Neuron state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      potential <= $signed(POT_W'(snpu_pkg::REST_RESET) << FRAC_BITS);
      active    <= 1'b0;
    end else begin
      if (ctl.rest) begin
        potential <= $signed(rest_val);
        active    <= 1'b1;
      end
      if (ctl.zsat) begin
        if (potential > 0) begin
          potential <= $signed(snpu_pkg::POT_MAX);
        end else if (potential < 0) begin
          potential <= $signed(snpu_pkg::POT_MIN);
        end
      end
      if (ctl.clamp) begin
        potential <= $signed(clamp_val);
      end
      if (ctl.fire && active && ($signed(potential) > $signed(thr_val))) begin
        active <= 1'b0;
      end
    end
  end

  // Per-item setup, multiply and divide registers.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      is_tick <= (cmd == snpu_pkg::CMD_TICK);
      sat     <= 1'b0;
      spike_r <= 1'b0;
      if (cmd == snpu_pkg::CMD_TICK) begin
        mul_mag <= factor;
        div_mag <= OPW'(snpu_pkg::PCT_SCALE);
        ops_neg <= 1'b0;
        steps   <= snpu_pkg::STEP_W'(1);
      end else begin
        mul_mag <= psp_power[snpu_pkg::POWER_W-1] ? base_ext : numer_mag;
        div_mag <= psp_power[snpu_pkg::POWER_W-1] ? numer_mag : base_ext;
        ops_neg <= numer_neg;
        steps   <= pw_mag;
      end
    end
    if (ctl.zsat) begin
      sat <= 1'b1;
    end
    if (ctl.mul) begin
      dvd     <= DVD_W'(prod);
      rem     <= '0;
      div_cnt <= '0;
      res_neg <= potential[POT_W-1] ^ ops_neg;
    end
    if (ctl.div) begin
      dvd     <= dvd_next;
      rem     <= rem_next;
      div_cnt <= div_cnt + 1'b1;
    end
    if (ctl.clamp) begin
      sat   <= sat | ovf;
      steps <= steps - 1'b1;
    end
    if (ctl.fire && active && ($signed(potential) > $signed(thr_val))) begin
      spike_r <= 1'b1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      spike         <= spike_r;
      potential_out <= potential;
      active_out    <= active;
      saturated     <= sat;
    end
  end

  // The divider remainder stays below the divisor.
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (ctl.div && div_mag != '0) |=> (rem < div_mag))
    else $error("divider remainder not below divisor");

  // Only a tick can fire a spike.
  a_spike_on_tick: assert property (@(posedge clk) disable iff (rst)
    (ctl.out_load && spike_r) |-> is_tick)
    else $error("spike raised on a synaptic transaction");

  // A tick never saturates the potential.
  a_tick_no_sat: assert property (@(posedge clk) disable iff (rst)
    (ctl.out_load && is_tick) |-> !sat)
    else $error("saturation flagged on a tick");

endmodule

`default_nettype wire
